FILE: sv/hmmr_pkg.sv
// Package with the shared widths, types and state encoding of the histogram rescale unit.
package hmmr_pkg;

    // Number of histogram bins in one frame.
    localparam int NUM_BINS = 32;

    // Field widths.
    localparam int BIN_W   = 32;
    localparam int LEVEL_W = 8;

    // Bin index width and the index of the final bin.
    localparam int IDX_W = $clog2(NUM_BINS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BINS - 1);

    // Dividend width: a bin difference times 255 needs eight more bits.
    localparam int NUM_W = BIN_W + LEVEL_W;

    // Divisor aligned to the top quotient bit.
    localparam int DIV_W = BIN_W + LEVEL_W - 1;

    // Width of the quotient bit counter.
    localparam int CNT_W = $clog2(LEVEL_W);

    // Request to the divider.
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [BIN_W-1:0] den;
    } t_div_req;

    // Response from the divider.
    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] quot;
    } t_div_rsp;

    // Control states of the top level.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_PREP,
        ST_SCALE,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

FILE: sv/hmmr_div.sv
// Bit-serial restoring divider that produces one quotient bit per cycle.
module hmmr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hmmr_pkg::t_div_req i_req,
    output hmmr_pkg::t_div_rsp o_rsp
);

    logic [hmmr_pkg::NUM_W-1:0]   r_rem;
    logic [hmmr_pkg::DIV_W-1:0]   r_div;
    logic [hmmr_pkg::LEVEL_W-1:0] r_quot;
    logic [hmmr_pkg::CNT_W-1:0]   r_cnt;
    logic                         r_busy;
    logic                         r_done;
    logic                         w_ge;

    // Trial subtraction of the shifted divisor from the partial remainder.
    assign w_ge = (r_rem >= {1'b0, r_div});

    // Control: busy while the quotient bits are produced, then a one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + hmmr_pkg::CNT_W'(1);
                if (r_cnt == hmmr_pkg::CNT_W'(hmmr_pkg::LEVEL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the divisor shifts right and quotient bits shift in from the right.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.num;
            r_div  <= {i_req.den, (hmmr_pkg::LEVEL_W - 1)'(0)};
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - {1'b0, r_div};
            end
            r_div  <= r_div >> 1;
            r_quot <= {r_quot[hmmr_pkg::LEVEL_W-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

FILE: sv/histogram_min_max_rescale_unit.sv
// Top level of the histogram min/max rescale unit.
// The unit takes one 32-bit bin count per cycle until a frame of NUM_BINS bins is complete,
// keeping the running minimum (lowered only by nonzero bins after the first) and maximum.
// It then emits one 8-bit level per bin in index order, with o_last_level set on the final
// one, and accepts no new bins until the last level has been taken. When the frame has a
// range, each level is produced in order: the stored bin is read, the difference is formed,
// the divider is started, the bit-serial divider runs until its done pulse, and the level is
// presented; a bin below the minimum skips the divider and gets level zero. A flat frame
// replays the stored levels.
module histogram_min_max_rescale_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [hmmr_pkg::BIN_W-1:0]   i_bin_count,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [hmmr_pkg::LEVEL_W-1:0] o_level,
    output logic                         o_last_level
);

    hmmr_pkg::t_state r_state;
    hmmr_pkg::t_state n_state;

    logic [hmmr_pkg::IDX_W-1:0]   r_idx;
    logic [hmmr_pkg::BIN_W-1:0]   r_min;
    logic [hmmr_pkg::BIN_W-1:0]   r_max;
    logic [hmmr_pkg::BIN_W-1:0]   n_min;
    logic [hmmr_pkg::BIN_W-1:0]   n_max;
    logic [hmmr_pkg::BIN_W-1:0]   r_den;
    logic [hmmr_pkg::BIN_W-1:0]   r_diff;
    logic                         r_scale;
    logic [hmmr_pkg::LEVEL_W-1:0] r_level;
    logic                         r_last;

    // Stores for the raw bins and the last emitted levels.
    logic [hmmr_pkg::BIN_W-1:0]   raw_mem [hmmr_pkg::NUM_BINS];
    logic [hmmr_pkg::LEVEL_W-1:0] lvl_mem [hmmr_pkg::NUM_BINS];
    logic [hmmr_pkg::NUM_BINS-1:0] r_lvl_vld;
    logic [hmmr_pkg::BIN_W-1:0]   r_raw_q;
    logic [hmmr_pkg::LEVEL_W-1:0] r_lvl_q;
    logic                         r_lvl_q_vld;

    logic                         w_in_acc;
    logic                         w_out_acc;
    logic                         w_lvl_we;
    logic [hmmr_pkg::LEVEL_W-1:0] w_lvl_wd;
    logic [hmmr_pkg::LEVEL_W-1:0] w_quot_adj;
    logic [hmmr_pkg::LEVEL_W-1:0] w_replay;
    logic                         w_div_start;

    hmmr_pkg::t_div_req w_div_req;
    hmmr_pkg::t_div_rsp w_div_rsp;

    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = o_valid && i_ready;

    // Running minimum and maximum after the incoming bin.
    always_comb begin
        n_min = r_min;
        n_max = r_max;
        if (r_idx == '0) begin
            n_min = i_bin_count;
            n_max = i_bin_count;
        end else if ((i_bin_count < r_min) && (i_bin_count != '0)) begin
            n_min = i_bin_count;
        end else if (i_bin_count > r_max) begin
            n_max = i_bin_count;
        end
    end

    // A quotient of zero is raised to one; a stored level never written reads as zero.
    assign w_quot_adj = (w_div_rsp.quot == '0) ? hmmr_pkg::LEVEL_W'(1) : w_div_rsp.quot;
    assign w_replay   = r_lvl_q_vld ? r_lvl_q : '0;

    // Divider request: the dividend is the bin difference times 255.
    assign w_div_req = '{start: w_div_start,
                         num:   {r_diff, hmmr_pkg::LEVEL_W'(0)}
                              - {hmmr_pkg::LEVEL_W'(0), r_diff},
                         den:   r_den};

    hmmr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hmmr_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and handshake outputs.
    always_comb begin
        n_state     = r_state;
        o_ready     = 1'b0;
        o_valid     = 1'b0;
        w_div_start = 1'b0;
        w_lvl_we    = 1'b0;
        w_lvl_wd    = w_quot_adj;
        case (r_state)
            hmmr_pkg::ST_LOAD: begin
                o_ready = 1'b1;
                if (i_valid && (r_idx == hmmr_pkg::LAST_IDX)) begin
                    n_state = hmmr_pkg::ST_READ;
                end
            end
            hmmr_pkg::ST_READ: begin
                n_state = hmmr_pkg::ST_PREP;
            end
            hmmr_pkg::ST_PREP: begin
                if (!r_scale) begin
                    n_state = hmmr_pkg::ST_OUT;
                end else if (r_raw_q < r_min) begin
                    w_lvl_we = 1'b1;
                    w_lvl_wd = '0;
                    n_state  = hmmr_pkg::ST_OUT;
                end else begin
                    n_state = hmmr_pkg::ST_SCALE;
                end
            end
            hmmr_pkg::ST_SCALE: begin
                w_div_start = 1'b1;
                n_state     = hmmr_pkg::ST_DIV;
            end
            hmmr_pkg::ST_DIV: begin
                if (w_div_rsp.done) begin
                    w_lvl_we = 1'b1;
                    n_state  = hmmr_pkg::ST_OUT;
                end
            end
            hmmr_pkg::ST_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = (r_idx == hmmr_pkg::LAST_IDX) ? hmmr_pkg::ST_LOAD
                                                            : hmmr_pkg::ST_READ;
                end
            end
            default: begin
                n_state = hmmr_pkg::ST_LOAD;
            end
        endcase
    end

    // Bin index, statistics and level valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_min     <= '0;
            r_max     <= '0;
            r_scale   <= 1'b0;
            r_lvl_vld <= '0;
        end else begin
            if (w_in_acc) begin
                r_min <= n_min;
                r_max <= n_max;
                if (r_idx == hmmr_pkg::LAST_IDX) begin
                    r_idx   <= '0;
                    r_scale <= (n_min != n_max);
                end else begin
                    r_idx <= r_idx + hmmr_pkg::IDX_W'(1);
                end
            end else if (w_out_acc) begin
                if (r_idx == hmmr_pkg::LAST_IDX) begin
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + hmmr_pkg::IDX_W'(1);
                end
            end
            if (w_lvl_we) begin
                r_lvl_vld[r_idx] <= 1'b1;
            end
        end
    end

    // Divisor captured at the end of the frame; difference formed per bin.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (r_idx == hmmr_pkg::LAST_IDX)) begin
            r_den <= n_max - n_min;
        end
        if (r_state == hmmr_pkg::ST_PREP) begin
            r_diff <= r_raw_q - r_min;
        end
    end

    // Raw bin store: written on each accepted bin, read with a registered port.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            raw_mem[r_idx] <= i_bin_count;
        end
        r_raw_q <= raw_mem[r_idx];
    end

    // Level store: written as each level is produced, read for replay.
    always_ff @(posedge i_clk) begin
        if (w_lvl_we) begin
            lvl_mem[r_idx] <= w_lvl_wd;
        end
        r_lvl_q     <= lvl_mem[r_idx];
        r_lvl_q_vld <= r_lvl_vld[r_idx];
    end

    // Output register, loaded as each level becomes ready.
    always_ff @(posedge i_clk) begin
        if (r_state == hmmr_pkg::ST_PREP) begin
            r_level <= r_scale ? '0 : w_replay;
            r_last  <= (r_idx == hmmr_pkg::LAST_IDX);
        end else if ((r_state == hmmr_pkg::ST_DIV) && w_div_rsp.done) begin
            r_level <= w_quot_adj;
        end
    end

    assign o_level      = r_level;
    assign o_last_level = r_last;

endmodule

FILE: test/hmmr_level_checker.sv
// Checker that predicts and compares the levels of the histogram rescale unit.
module hmmr_level_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_bin_valid,
    input  logic                         i_bin_ready,
    input  logic [hmmr_pkg::BIN_W-1:0]   i_bin_count,
    input  logic                         i_level_valid,
    input  logic                         i_level_ready,
    input  logic [hmmr_pkg::LEVEL_W-1:0] i_level,
    input  logic                         i_last_level,
    output int                           o_fail_count,
    output int                           o_pending
);

    localparam int REPORT_LIMIT = 10;

    // One level that the unit owes us.
    typedef struct packed {
        logic [hmmr_pkg::LEVEL_W-1:0] level;
        logic                         last;
    } t_level_item;

    // Predicted copy of the unit's state.
    logic [hmmr_pkg::BIN_W-1:0]   frame_bins   [hmmr_pkg::NUM_BINS];
    logic [hmmr_pkg::LEVEL_W-1:0] shown_levels [hmmr_pkg::NUM_BINS];
    logic [hmmr_pkg::BIN_W-1:0]   bin_min;
    logic [hmmr_pkg::BIN_W-1:0]   bin_max;
    int                           next_bin;

    t_level_item due_levels [$];
    int          mismatch_total = 0;

    // Level of one bin against the frame's range; the product is kept exact in 64 bits.
    function automatic logic [hmmr_pkg::LEVEL_W-1:0] rescale_bin(
        input logic [hmmr_pkg::BIN_W-1:0] v);
        logic [63:0] scaled;
        logic [63:0] quot;
        if (v < bin_min) return '0;
        scaled = 64'(v - bin_min) * 64'd255;
        quot   = scaled / 64'(bin_max - bin_min);
        if (quot > 64'd255) quot = 64'd255;
        if (quot == 64'd0) quot = 64'd1;
        return quot[hmmr_pkg::LEVEL_W-1:0];
    endfunction

    // Takes one bin request; the final bin of a frame queues a whole frame of levels.
    function automatic void absorb_bin(input logic [hmmr_pkg::BIN_W-1:0] v);
        int          k;
        t_level_item lv;
        frame_bins[next_bin] = v;
        if (next_bin == 0) begin
            bin_min = v;
            bin_max = v;
        end else if (v < bin_min && v != '0) begin
            bin_min = v;
        end else if (v > bin_max) begin
            bin_max = v;
        end
        if (next_bin < hmmr_pkg::NUM_BINS - 1) begin
            next_bin++;
            return;
        end
        next_bin = 0;
        // A flat frame leaves the previous levels in place and sends them again.
        if (bin_min != bin_max) begin
            for (k = 0; k < hmmr_pkg::NUM_BINS; k++)
                shown_levels[k] = rescale_bin(frame_bins[k]);
        end
        for (k = 0; k < hmmr_pkg::NUM_BINS; k++) begin
            lv.level = shown_levels[k];
            lv.last  = (k == hmmr_pkg::NUM_BINS - 1);
            due_levels.push_back(lv);
        end
    endfunction

    // Back to the state after reset.
    function automatic void clear_prediction();
        int k;
        for (k = 0; k < hmmr_pkg::NUM_BINS; k++) begin
            frame_bins[k]   = '0;
            shown_levels[k] = '0;
        end
        bin_min  = '0;
        bin_max  = '0;
        next_bin = 0;
        due_levels.delete();
    endfunction

    // Levels are checked before bins are taken, so a frame is never compared with itself.
    always @(posedge i_clk) begin : watch
        t_level_item want;
        if (!i_rst_n) begin
            clear_prediction();
        end else begin
            if (i_level_valid && i_level_ready) begin
                if (due_levels.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= REPORT_LIMIT)
                        $display("level %0d last %0b arrived with nothing due",
                                 i_level, i_last_level);
                end else begin
                    want = due_levels.pop_front();
                    if (i_level !== want.level || i_last_level !== want.last) begin
                        mismatch_total++;
                        if (mismatch_total <= REPORT_LIMIT)
                            $display("level mismatch: expected %0d last %0b, got %0d last %0b",
                                     want.level, want.last, i_level, i_last_level);
                    end
                end
            end
            if (i_bin_valid && i_bin_ready) absorb_bin(i_bin_count);
        end
        o_pending    <= due_levels.size();
        o_fail_count <= mismatch_total;
    end

endmodule

FILE: test/testbench.sv
// Testbench top that drives histogram frames into the rescale unit and gives the verdict.
module testbench;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int SETTLE_CYCLES = 40;

    // Shapes of histogram frame that the stimulus can send.
    typedef enum logic [2:0] {
        FR_ZERO_FLAT,
        FR_EXTREMES,
        FR_HELD_FLAT,
        FR_ZERO_FIRST,
        FR_WIDE,
        FR_NARROW,
        FR_SPARSE
    } t_frame_kind;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic [hmmr_pkg::BIN_W-1:0]   i_bin_count;
    logic                         o_valid;
    logic                         i_ready;
    logic [hmmr_pkg::LEVEL_W-1:0] o_level;
    logic                         o_last_level;

    int                         fail_count;
    int                         levels_due;
    int                         cycle_count = 0;
    bit                         calm = 1'b0;
    logic [hmmr_pkg::BIN_W-1:0] frame_pattern [hmmr_pkg::NUM_BINS];

    histogram_min_max_rescale_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_bin_count  (i_bin_count),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_level      (o_level),
        .o_last_level (o_last_level)
    );

    hmmr_level_checker u_level_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bin_valid   (i_valid),
        .i_bin_ready   (o_ready),
        .i_bin_count   (i_bin_count),
        .i_level_valid (o_valid),
        .i_level_ready (i_ready),
        .i_level       (o_level),
        .i_last_level  (o_last_level),
        .o_fail_count  (fail_count),
        .o_pending     (levels_due)
    );

    // Clock with a period of two units.
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Guard against a hang.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL histogram_min_max_rescale_unit");
            $finish;
        end
    end

    // Fills frame_pattern with one frame of the given shape.
    function automatic void build_frame(input t_frame_kind kind);
        logic [hmmr_pkg::BIN_W-1:0] base;
        int                         k;
        int                         pick;
        base = $urandom | 32'h1;
        for (k = 0; k < hmmr_pkg::NUM_BINS; k++) begin
            pick = $urandom_range(0, 9);
            case (kind)
                FR_ZERO_FLAT: begin
                    frame_pattern[k] = '0;
                end
                FR_EXTREMES: begin
                    // Full scale, zeros below the minimum and bins just above it.
                    case (k % 6)
                        0: frame_pattern[k] = 32'hFFFF_FFFF;
                        1: frame_pattern[k] = 32'h0;
                        2: frame_pattern[k] = 32'h1;
                        3: frame_pattern[k] = 32'h2;
                        4: frame_pattern[k] = 32'hFFFF_FFFE;
                        default: frame_pattern[k] = $urandom;
                    endcase
                end
                FR_HELD_FLAT: begin
                    // Zeros never lower the minimum, so this frame is still flat.
                    frame_pattern[k] = (k != 0 && pick < 3) ? '0 : base;
                end
                FR_ZERO_FIRST: begin
                    frame_pattern[k] = (k == 0) ? '0
                                     : hmmr_pkg::BIN_W'($urandom_range(0, 5000));
                end
                FR_WIDE: begin
                    if (pick == 0)      frame_pattern[k] = '0;
                    else if (pick == 1) frame_pattern[k] = 32'hFFFF_FFFF;
                    else                frame_pattern[k] = $urandom;
                end
                FR_NARROW: begin
                    frame_pattern[k] = (base & 32'hFFFF_F000)
                                     + hmmr_pkg::BIN_W'($urandom_range(0, 300));
                end
                default: begin
                    if (k == 0)         frame_pattern[k] = (base >> 1) | 32'h1;
                    else if (pick < 3)  frame_pattern[k] = '0;
                    else if (pick == 3) frame_pattern[k] = (base >> 3) | 32'h1;
                    else                frame_pattern[k] = $urandom;
                end
            endcase
        end
    endfunction

    // Offers one bin request, sometimes after a random gap, and waits for it to be taken.
    task automatic send_bin(input logic [hmmr_pkg::BIN_W-1:0] v);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_bin_count <= v;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic run_frame(input t_frame_kind kind);
        int k;
        build_frame(kind);
        for (k = 0; k < hmmr_pkg::NUM_BINS; k++) send_bin(frame_pattern[k]);
    endtask

    // Lowers valid and waits until every level owed has been taken.
    task automatic drain_levels();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (levels_due != 0);
    endtask

    // Receiver side: bursts of ready with random stalls, always ready once calm.
    initial begin : level_sink
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 60)) @(posedge i_clk);
            if (!calm) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
        end
    end

    // Stimulus: directed frames first, then random ones, the last without idling.
    initial begin : stimulus
        int f;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_bin_count <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_frame(FR_ZERO_FLAT);
        run_frame(FR_EXTREMES);
        run_frame(FR_HELD_FLAT);
        drain_levels();
        run_frame(FR_ZERO_FIRST);

        for (f = 0; f < 3; f++) begin
            if (f == 2) calm = 1'b1;
            run_frame(t_frame_kind'($urandom_range(FR_HELD_FLAT, FR_SPARSE)));
        end

        drain_levels();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS histogram_min_max_rescale_unit");
        end else begin
            $display("FAIL histogram_min_max_rescale_unit");
        end
        $finish;
    end

endmodule
